// ----- rtl/gcd_pkg.sv -----
// shared constants and arithmetic helpers for the great-circle distance unit
package gcd_pkg;

   // datapath width of the cordic cells and the angle lanes
   localparam int CW = 34;
   // width of the digit-by-digit square root datapath
   localparam int SQW = 62;
   // root steps for a radicand below 2^62, two bits a step
   localparam int SQRT_STEPS = 31;
   // fixed register stages of the angle lanes, input word register included
   localparam int ANGLE_LAT = 5;

   localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;
   localparam logic signed [CW-1:0] GAIN_INV    = 34'sd652032874;
   localparam logic signed [CW-1:0] TURN_U24    = 34'sd6039797760;
   localparam logic signed [CW-1:0] HALF_U24    = 34'sd3019898880;
   localparam logic signed [CW-1:0] QUARTER_U24 = 34'sd1509949440;

   // pi_Q31 / 180 split as integer part plus 13/45
   localparam logic [25:0] PI_DEG_INT  = 26'd37480660;
   // ceil(2^37 / 45), exact floor division by 45 below 2^31
   localparam logic [31:0] RECIP_45    = 32'd3054198967;
   localparam int          RECIP_SHIFT = 37;

   localparam logic [22:0] RADIUS_RESET = 23'd6371000;

   function automatic logic signed [CW-1:0] atan_step(input int i);
      logic signed [CW-1:0] r;
      case (i)
         0: r = 34'sd843314857;
         1: r = 34'sd497837829;
         2: r = 34'sd263043837;
         3: r = 34'sd133525159;
         4: r = 34'sd67021687;
         5: r = 34'sd33543516;
         6: r = 34'sd16775851;
         7: r = 34'sd8388437;
         8: r = 34'sd4194283;
         9: r = 34'sd2097149;
         default: r = (i <= 30) ? ($signed({{(CW-1){1'b0}}, 1'b1}) <<< (30 - i)) : '0;
      endcase
      return r;
   endfunction

   // clamp to [-1, 1] in q30
   function automatic logic signed [31:0] clamp_q30(input logic signed [CW-1:0] v);
      logic signed [31:0] r;
      if (v > Q30_ONE) r = 32'sd1073741824;
      else if (v < -Q30_ONE) r = -32'sd1073741824;
      else r = 32'(v);
      return r;
   endfunction

   // q30 product, rounded half away from zero
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] p,
                                                  input logic signed [31:0] q);
      logic [30:0] mp;
      logic [30:0] mq;
      logic [61:0] pr;
      logic [31:0] r;
      mp = p[31] ? 31'(-p) : p[30:0];
      mq = q[31] ? 31'(-q) : q[30:0];
      pr = 62'(mp) * 62'(mq) + 62'd536870912;
      r = 32'(pr >> 30);
      return (p[31] ^ q[31]) ? $signed(-r) : $signed(r);
   endfunction

   // floor(13 * w / 45) for a remainder w below 45
   function automatic logic [3:0] frac_13_45(input logic [5:0] w);
      logic [3:0] r;
      logic [9:0] t;
      r = '0;
      t = 10'(w) * 10'd13;
      for (int k = 1; k <= 12; k++) begin
         if (t >= 10'(45 * k)) r = r + 4'd1;
      end
      return r;
   endfunction

endpackage

// ----- rtl/great_circle_distance_unit.sv -----
// top level of the haversine great-circle distance unit
//
//  channel   ports                                   handshake
//  request   req_lat_a req_lon_a req_lat_b req_lon_b start high, busy low
//  response  rsp_distance_mm                         rsp_valid for one cycle
//  csr       csr_earth_radius_m                      csr_valid and csr_ready
//
// one word accepted every cycle, busy never rises
// a word passes through two cordic chains and the 31-cell root chain
// no flow control inside: every cell hands its word on each cycle
// reset clears the valid line and loads the radius, payload is not reset
// the receiver cannot stall, so no result buffering is kept
module great_circle_distance_unit #(
   parameter int CORDIC_STAGES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [30:0] req_lat_a,
   input  logic signed [31:0] req_lon_a,
   input  logic signed [30:0] req_lat_b,
   input  logic signed [31:0] req_lon_b,
   output logic               rsp_valid,
   output logic [34:0]        rsp_distance_mm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [22:0]        csr_earth_radius_m
);

   localparam int CW  = gcd_pkg::CW;
   localparam int SQW = gcd_pkg::SQW;
   localparam int NSQ = gcd_pkg::SQRT_STEPS;
   // register stages from accept to result
   localparam int LAT = gcd_pkg::ANGLE_LAT + CORDIC_STAGES + 4 + NSQ + 1 + CORDIC_STAGES + 2;
   // valid line tap that lines up with the rounded roots
   localparam int RND_IDX = gcd_pkg::ANGLE_LAT + CORDIC_STAGES + 4 + NSQ;

   // lanes: 0 half latitude difference, 1 half longitude difference,
   // 2 latitude a, 3 latitude b
   logic signed [CW-1:0] v_ff [4];
   logic signed [CW-1:0] v_in [4];
   logic signed [CW-1:0] theta [4];
   logic                 flip [4];

   logic signed [CW-1:0] cx [4][0:CORDIC_STAGES];
   logic signed [CW-1:0] cy [4][0:CORDIC_STAGES];
   logic signed [CW-1:0] cz [4][0:CORDIC_STAGES];

   logic [CORDIC_STAGES-1:0] flipa_ff, flipa_in, flipb_ff, flipb_in;
   logic [LAT-1:0]           valid_ff, valid_in;
   logic [22:0]              radius_ff, radius_in;

   logic signed [31:0] sd_ff, sl_ff, c1_ff, c2_ff;
   logic signed [31:0] p1_ff, p2_ff, p3_ff, p1d_ff, p4_ff;
   logic signed [32:0] asum;
   logic [30:0]        a_ff, a_in;

   logic [SQW-1:0] sn [2][0:NSQ];
   logic [SQW-1:0] sr [2][0:NSQ];
   logic [31:0]    sy_ff, sx_ff;

   logic signed [CW-1:0] vx [0:CORDIC_STAGES];
   logic signed [CW-1:0] vy [0:CORDIC_STAGES];
   logic signed [CW-1:0] vz [0:CORDIC_STAGES];

   logic [30:0] zc;
   logic [53:0] t_ff;
   logic [41:0] frac;
   logic [35:0] dist_sum;
   logic [34:0] dist_ff;

   logic accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // control: valid line and radius register
   always_comb begin
      valid_in  = {valid_ff[LAT-2:0], accept};
      radius_in = (csr_valid && csr_ready) ? csr_earth_radius_m : radius_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         radius_ff <= gcd_pkg::RADIUS_RESET;
      end else begin
         valid_ff  <= valid_in;
         radius_ff <= radius_in;
      end
   end

   // angles in 2^-24 degree: half differences and doubled latitudes
   always_comb begin
      v_in[0] = CW'(req_lat_b) - CW'(req_lat_a);
      v_in[1] = CW'(req_lon_b) - CW'(req_lon_a);
      v_in[2] = CW'(req_lat_a) <<< 1;
      v_in[3] = CW'(req_lat_b) <<< 1;
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) v_ff[l] <= v_in[l];
   end

   // rotation cordic chains, one per angle lane
   for (genvar l = 0; l < 4; l++) begin : g_lane
      gcd_angle u_angle (
         .clock     (clock),
         .src_v     (v_ff[l]),
         .dst_theta (theta[l]),
         .dst_flip  (flip[l])
      );

      assign cx[l][0] = gcd_pkg::GAIN_INV;
      assign cy[l][0] = '0;
      assign cz[l][0] = theta[l];

      for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
         gcd_cordic_cell #(.STEP(s), .VECTOR(1'b0)) u_cell (
            .clock (clock),
            .src_x (cx[l][s]),
            .src_y (cy[l][s]),
            .src_z (cz[l][s]),
            .dst_x (cx[l][s+1]),
            .dst_y (cy[l][s+1]),
            .dst_z (cz[l][s+1])
         );
      end
   end

   // cosine sign of the latitudes rides alongside the chain
   always_comb begin
      flipa_in = {flipa_ff[CORDIC_STAGES-2:0], flip[2]};
      flipb_in = {flipb_ff[CORDIC_STAGES-2:0], flip[3]};
   end

   // clamp, then the haversine products, one multiply level per stage, then the saturated sum a
   always_comb begin
      asum = 33'(p1d_ff) + 33'(p4_ff);
      if (asum < 0) a_in = '0;
      else if (asum > 33'sd1073741824) a_in = 31'd1073741824;
      else a_in = asum[30:0];
   end

   always_ff @(posedge clock) begin
      flipa_ff <= flipa_in;
      flipb_ff <= flipb_in;
      sd_ff    <= gcd_pkg::clamp_q30(cy[0][CORDIC_STAGES]);
      sl_ff    <= gcd_pkg::clamp_q30(cy[1][CORDIC_STAGES]);
      c1_ff    <= flipa_ff[CORDIC_STAGES-1] ? -gcd_pkg::clamp_q30(cx[2][CORDIC_STAGES])
                                            : gcd_pkg::clamp_q30(cx[2][CORDIC_STAGES]);
      c2_ff    <= flipb_ff[CORDIC_STAGES-1] ? -gcd_pkg::clamp_q30(cx[3][CORDIC_STAGES])
                                            : gcd_pkg::clamp_q30(cx[3][CORDIC_STAGES]);
      p1_ff    <= gcd_pkg::mul_q30(sd_ff, sd_ff);
      p2_ff    <= gcd_pkg::mul_q30(c1_ff, c2_ff);
      p3_ff    <= gcd_pkg::mul_q30(sl_ff, sl_ff);
      p1d_ff   <= p1_ff;
      p4_ff    <= gcd_pkg::mul_q30(p2_ff, p3_ff);
      a_ff     <= a_in;
   end

   // square roots of a and 1 - a, both scaled by 2^30
   assign sn[0][0] = SQW'(a_ff) << 30;
   assign sn[1][0] = (SQW'(gcd_pkg::Q30_ONE) - SQW'(a_ff)) << 30;
   assign sr[0][0] = '0;
   assign sr[1][0] = '0;

   for (genvar r = 0; r < 2; r++) begin : g_root
      for (genvar k = 0; k < NSQ; k++) begin : g_step
         gcd_sqrt_cell #(.BIT_POS(2 * (NSQ - 1 - k))) u_cell (
            .clock (clock),
            .src_n (sn[r][k]),
            .src_r (sr[r][k]),
            .dst_n (sn[r][k+1]),
            .dst_r (sr[r][k+1])
         );
      end
   end

   // round to nearest from the remainder
   always_ff @(posedge clock) begin
      sy_ff <= 32'(sr[0][NSQ] + SQW'(sn[0][NSQ] > sr[0][NSQ]));
      sx_ff <= 32'(sr[1][NSQ] + SQW'(sn[1][NSQ] > sr[1][NSQ]));
   end

   // vectoring cordic for atan2(sqrt a, sqrt(1 - a))
   assign vx[0] = $signed(CW'(sx_ff));
   assign vy[0] = $signed(CW'(sy_ff));
   assign vz[0] = '0;

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
      gcd_cordic_cell #(.STEP(s), .VECTOR(1'b1)) u_cell (
         .clock (clock),
         .src_x (vx[s]),
         .src_y (vy[s]),
         .src_z (vz[s]),
         .dst_x (vx[s+1]),
         .dst_y (vy[s+1]),
         .dst_z (vz[s+1])
      );
   end

   // scale the central angle: R * 2000 * z / 2^30, rounded
   always_comb begin
      zc       = vz[CORDIC_STAGES][CW-1] ? '0 : vz[CORDIC_STAGES][30:0];
      frac     = 42'(t_ff[29:0]) * 42'd2000 + 42'd536870912;
      dist_sum = 36'(t_ff[53:30]) * 36'd2000 + 36'(frac >> 30);
   end

   always_ff @(posedge clock) begin
      t_ff    <= 54'(radius_ff) * 54'(zc);
      dist_ff <= dist_sum[34:0];
   end

   assign rsp_valid       = valid_ff[LAT-1];
   assign rsp_distance_mm = dist_ff;

   // a result only ever leaves a fixed latency after an accepted word
   a_result_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without matching accepted word");

   // saturated a keeps both rounded roots within one
   a_roots_bounded: assert property (@(posedge clock) disable iff (reset)
      valid_ff[RND_IDX] |-> (sy_ff <= 32'd1073741824) && (sx_ff <= 32'd1073741824))
      else $error("square root out of unit range");

   // the unit never refuses a word
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy && csr_ready)
      else $error("unit stalled a request");

endmodule

// ----- rtl/gcd_cordic_cell.sv -----
// one cordic micro-rotation cell, rotation or vectoring mode, registered outputs
module gcd_cordic_cell #(
   parameter int STEP   = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic                            clock,
   input  logic signed [gcd_pkg::CW-1:0]   src_x,
   input  logic signed [gcd_pkg::CW-1:0]   src_y,
   input  logic signed [gcd_pkg::CW-1:0]   src_z,
   output logic signed [gcd_pkg::CW-1:0]   dst_x,
   output logic signed [gcd_pkg::CW-1:0]   dst_y,
   output logic signed [gcd_pkg::CW-1:0]   dst_z
);

   logic signed [gcd_pkg::CW-1:0] x_ff, y_ff, z_ff;
   logic signed [gcd_pkg::CW-1:0] x_in, y_in, z_in;
   logic signed [gcd_pkg::CW-1:0] dx, dy, ang;
   logic                          ccw;

   always_comb begin
      dx  = src_y >>> STEP;
      dy  = src_x >>> STEP;
      ang = gcd_pkg::atan_step(STEP);
      // vectoring drives y to zero, rotation drives z to zero
      ccw = VECTOR ? src_y[gcd_pkg::CW-1] : !src_z[gcd_pkg::CW-1];
      if (ccw) begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - ang;
      end else begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + ang;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign dst_x = x_ff;
   assign dst_y = y_ff;
   assign dst_z = z_ff;

endmodule

// ----- rtl/gcd_sqrt_cell.sv -----
// one step of the digit-by-digit square root, two radicand bits per cell
module gcd_sqrt_cell #(
   parameter int BIT_POS = 60
) (
   input  logic                      clock,
   input  logic [gcd_pkg::SQW-1:0]   src_n,
   input  logic [gcd_pkg::SQW-1:0]   src_r,
   output logic [gcd_pkg::SQW-1:0]   dst_n,
   output logic [gcd_pkg::SQW-1:0]   dst_r
);

   logic [gcd_pkg::SQW-1:0] n_ff, r_ff, n_in, r_in;
   logic [gcd_pkg::SQW-1:0] bitv, trial;

   always_comb begin
      bitv  = {{(gcd_pkg::SQW-1){1'b0}}, 1'b1} << BIT_POS;
      trial = src_r + bitv;
      if (src_n >= trial) begin
         n_in = src_n - trial;
         r_in = (src_r >> 1) + bitv;
      end else begin
         n_in = src_n;
         r_in = src_r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      r_ff <= r_in;
   end

   assign dst_n = n_ff;
   assign dst_r = r_ff;

endmodule

// ----- rtl/gcd_angle.sv -----
// angle lane: wrap to a half turn, fold to a quarter, convert to q2.30 radians
module gcd_angle (
   input  logic                            clock,
   input  logic signed [gcd_pkg::CW-1:0]   src_v,
   output logic signed [gcd_pkg::CW-1:0]   dst_theta,
   output logic                            dst_flip
);

   logic signed [gcd_pkg::CW-1:0] wrap_ff, wrap_in;
   logic signed [gcd_pkg::CW-1:0] fold;
   logic [30:0] mag_ff, mag_in, mag3_ff;
   logic        neg_ff, neg_in, neg3_ff;
   logic        flip_ff, flip_in, flip3_ff, flip4_ff;
   logic [62:0] pr_ff, pr_in;
   logic [56:0] pq_ff, pq_in;
   logic signed [gcd_pkg::CW-1:0] theta_ff, theta_in;
   logic [25:0] quo;
   logic [30:0] rem_full;
   logic [57:0] sum;
   logic [32:0] rad;

   // reduce to [-half, half)
   always_comb begin
      if (src_v >= gcd_pkg::HALF_U24) wrap_in = src_v - gcd_pkg::TURN_U24;
      else if (src_v < -gcd_pkg::HALF_U24) wrap_in = src_v + gcd_pkg::TURN_U24;
      else wrap_in = src_v;
   end

   // fold into [-quarter, quarter], cosine sign flips
   always_comb begin
      flip_in = 1'b1;
      if (wrap_ff > gcd_pkg::QUARTER_U24) fold = gcd_pkg::HALF_U24 - wrap_ff;
      else if (wrap_ff < -gcd_pkg::QUARTER_U24) fold = -gcd_pkg::HALF_U24 - wrap_ff;
      else begin
         fold    = wrap_ff;
         flip_in = 1'b0;
      end
      neg_in = fold[gcd_pkg::CW-1];
      mag_in = neg_in ? 31'(-fold) : 31'(fold);
   end

   always_comb begin
      pr_in = 63'(mag_ff) * 63'(gcd_pkg::RECIP_45);
      pq_in = 57'(mag_ff) * 57'(gcd_pkg::PI_DEG_INT);
   end

   always_comb begin
      quo      = pr_ff[62:gcd_pkg::RECIP_SHIFT];
      rem_full = mag3_ff - 31'(31'(quo) * 31'd45);
      sum      = 58'(pq_ff) + 58'(quo) * 58'd13 + 58'(gcd_pkg::frac_13_45(rem_full[5:0]));
      rad      = 33'((sum + 58'd16777216) >> 25);
      theta_in = neg3_ff ? -$signed(gcd_pkg::CW'(rad[30:0]))
                         : $signed(gcd_pkg::CW'(rad[30:0]));
   end

   always_ff @(posedge clock) begin
      wrap_ff  <= wrap_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      flip_ff  <= flip_in;
      pr_ff    <= pr_in;
      pq_ff    <= pq_in;
      mag3_ff  <= mag_ff;
      neg3_ff  <= neg_ff;
      flip3_ff <= flip_ff;
      theta_ff <= theta_in;
      flip4_ff <= flip3_ff;
   end

   assign dst_theta = theta_ff;
   assign dst_flip  = flip4_ff;

endmodule
